@@ rtl/percent_decoder_assert.svh @@
// Assertion helpers for the RTL files; pd_back includes them.
`ifndef PERCENT_DECODER_ASSERT_SVH
`define PERCENT_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("percent_decoder check failed");

// Next-cycle implication, checked outside reset.
`define PD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("percent_decoder check failed");

`endif

@@ rtl/pd_pkg.sv @@
package pd_pkg;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [3:0] HEX_TEN    = 4'd10;

   localparam logic CSR_PLUS_AS_SPACE = 1'b0;
   localparam logic CSR_OUTPUT_LIMIT  = 1'b1;

   localparam logic [15:0] OUTPUT_LIMIT_RESET = 16'hFFFF;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_BITS = 2;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_HIGH = 2'd1,
      PH_LOW  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_MALFORMED = 2'd1,
      ERR_OVERFLOW  = 2'd2
   } err_type;

   typedef struct packed {
      logic        plus_as_space;
      logic [15:0] output_limit;
   } cfg_type;

   // One classified input beat.
   typedef struct packed {
      logic [7:0] raw;
      logic       last;
      logic       is_percent;
      logic       is_plus;
      logic       is_hex;
      logic [3:0] hex_val;
   } item_type;

endpackage

@@ rtl/pd_front.sv @@
module pd_front
   import pd_pkg::*;
(
   input  logic     [7:0] req_byte_in,
   input  logic           req_last_byte,
   output item_type       item
);

   logic [7:0] upper_off;
   logic [7:0] lower_off;
   logic [7:0] digit_off;

   assign digit_off = req_byte_in - CH_ZERO;
   assign upper_off = req_byte_in - CH_UPPER_A;
   assign lower_off = req_byte_in - CH_LOWER_A;

   always_comb begin
      item.raw        = req_byte_in;
      item.last       = req_last_byte;
      item.is_percent = (req_byte_in == CH_PERCENT);
      item.is_plus    = (req_byte_in == CH_PLUS);
      item.is_hex     = 1'b0;
      item.hex_val    = 4'd0;
      if (req_byte_in >= CH_ZERO && req_byte_in <= CH_NINE) begin
         item.is_hex  = 1'b1;
         item.hex_val = digit_off[3:0];
      end else if (req_byte_in >= CH_UPPER_A && req_byte_in <= CH_UPPER_F) begin
         item.is_hex  = 1'b1;
         item.hex_val = upper_off[3:0] + HEX_TEN;
      end else if (req_byte_in >= CH_LOWER_A && req_byte_in <= CH_LOWER_F) begin
         item.is_hex  = 1'b1;
         item.hex_val = lower_off[3:0] + HEX_TEN;
      end
   end

endmodule

@@ rtl/pd_queue.sv @@
module pd_queue
   import pd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     not_empty
);

   item_type                entry_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_BITS:0]     count_ff, count_in;

   assign full      = (count_ff == (Q_PTR_BITS+1)'(Q_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/pd_back.sv @@
`include "percent_decoder_assert.svh"

module pd_back
   import pd_pkg::*;
#(
   parameter int LENGTH_BITS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_decoded_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_string_done,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_decoded_length
);

   localparam int ExtW = LENGTH_BITS + 16;

   phase_type              phase_ff, phase_in;
   err_type                err_ff, err_in;
   logic [3:0]             nibble_ff, nibble_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             out_byte_ff;
   logic                   out_bvalid_ff;
   logic                   out_done_ff;
   logic [1:0]             out_status_ff;
   logic [15:0]            out_len_ff;

   logic                   emit;
   logic [7:0]             dbyte;
   logic [ExtW-1:0]        cap_ext, lim_ext, limit_ext, cnt_ext, cnt_next_ext;
   logic [1:0]             status_w;
   logic [15:0]            len_w;

   // output register frees up when empty or being drained this cycle
   assign q_pop = q_valid && (!rsp_valid_ff || rsp_ready);

   assign cap_ext   = {{16{1'b0}}, {LENGTH_BITS{1'b1}}};
   assign lim_ext   = {{LENGTH_BITS{1'b0}}, cfg.output_limit};
   assign limit_ext = (lim_ext < cap_ext) ? lim_ext : cap_ext;
   assign cnt_ext   = {{16{1'b0}}, count_ff};

   always_comb begin
      phase_in  = phase_ff;
      err_in    = err_ff;
      nibble_in = nibble_ff;
      count_in  = count_ff;
      emit      = 1'b0;
      dbyte     = 8'd0;
      if (err_ff == ERR_NONE) begin
         unique case (phase_ff)
            PH_HIGH: begin
               if (!q_item.is_hex) begin
                  err_in = ERR_MALFORMED;
               end else begin
                  nibble_in = q_item.hex_val;
                  phase_in  = PH_LOW;
               end
            end
            PH_LOW: begin
               if (!q_item.is_hex) begin
                  err_in = ERR_MALFORMED;
               end else begin
                  dbyte = {nibble_ff, q_item.hex_val};
                  emit  = 1'b1;
               end
               phase_in = PH_IDLE;
            end
            default: begin
               // idle, and the unused phase code behaves the same
               phase_in = PH_IDLE;
               if (q_item.is_percent) begin
                  phase_in = PH_HIGH;
               end else if (cfg.plus_as_space && q_item.is_plus) begin
                  dbyte = CH_SPACE;
                  emit  = 1'b1;
               end else begin
                  dbyte = q_item.raw;
                  emit  = 1'b1;
               end
            end
         endcase
         if (emit) begin
            if (cnt_ext >= limit_ext) begin
               err_in = ERR_OVERFLOW;
               emit   = 1'b0;
               dbyte  = 8'd0;
            end else begin
               count_in = count_ff + LENGTH_BITS'(1);
            end
         end
         if (q_item.last && err_in == ERR_NONE && phase_in != PH_IDLE) begin
            err_in = ERR_MALFORMED;
         end
      end
   end

   assign cnt_next_ext = {{16{1'b0}}, count_in};
   assign status_w = q_item.last ? err_in : 2'd0;
   assign len_w    = (q_item.last && err_in == ERR_NONE) ? cnt_next_ext[15:0] : 16'd0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         err_ff       <= ERR_NONE;
         nibble_ff    <= 4'd0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            if (q_item.last) begin
               phase_ff  <= PH_IDLE;
               err_ff    <= ERR_NONE;
               nibble_ff <= 4'd0;
               count_ff  <= '0;
            end else begin
               phase_ff  <= phase_in;
               err_ff    <= err_in;
               nibble_ff <= nibble_in;
               count_ff  <= count_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_byte_ff   <= dbyte;
         out_bvalid_ff <= emit;
         out_done_ff   <= q_item.last;
         out_status_ff <= status_w;
         out_len_ff    <= len_w;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_decoded_byte   = out_byte_ff;
   assign rsp_byte_valid     = out_bvalid_ff;
   assign rsp_string_done    = out_done_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_decoded_length = out_len_ff;

   // a beat that carries a byte and closes the string can only be clean
   `PD_ASSERT_NOW(a_emit_done_ok, clock, reset,
      rsp_valid_ff && out_bvalid_ff && out_done_ff, out_status_ff == ERR_NONE)
   `PD_ASSERT_NOW(a_no_byte_zero, clock, reset,
      rsp_valid_ff && !out_bvalid_ff, out_byte_ff == 8'd0)
   `PD_ASSERT_NOW(a_len_only_done, clock, reset,
      rsp_valid_ff && !out_done_ff, out_len_ff == 16'd0 && out_status_ff == ERR_NONE)
   `PD_ASSERT_NEXT(a_last_clears, clock, reset,
      q_pop && q_item.last, phase_ff == PH_IDLE && err_ff == ERR_NONE && count_ff == '0)

endmodule

@@ rtl/percent_decoder.sv @@
// Streaming URL percent-decoder. One raw byte enters per beat (req_last_byte marks
// the end of a string) and exactly one result beat leaves for it, in order. "%HH"
// (hex digits in either case) yields one byte, '+' yields a space when
// plus_as_space is set, and everything else passes through. The first error
// (bad or truncated escape, or more decoded bytes than output_limit) ends output
// for the rest of the string; the result for the last byte carries status and
// the decoded length. Throughput is one byte per clock while rsp_ready holds: the
// classifier feeds a four-entry queue and the decode state machine updates its
// state once per beat, so a beat accepted at req_ passes through a queue entry
// and the output register before it shows up on rsp_.
// LENGTH_BITS sizes the per-string byte counter and caps the effective limit.
module percent_decoder
   import pd_pkg::*;
#(
   parameter int LENGTH_BITS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_decoded_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_string_done,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_decoded_length
);

   cfg_type  cfg_ff, cfg_in;
   item_type front_item;
   item_type q_item;
   logic     q_full;
   logic     q_valid;
   logic     q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PLUS_AS_SPACE: cfg_in.plus_as_space = csr_wdata[0];
            CSR_OUTPUT_LIMIT:  cfg_in.output_limit  = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.plus_as_space <= 1'b0;
         cfg_ff.output_limit  <= OUTPUT_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready = !q_full;

   pd_front u_front (
      .req_byte_in   (req_byte_in),
      .req_last_byte (req_last_byte),
      .item          (front_item)
   );

   pd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !q_full),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_item),
      .not_empty (q_valid)
   );

   pd_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_decoded_byte   (rsp_decoded_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_string_done    (rsp_string_done),
      .rsp_status         (rsp_status),
      .rsp_decoded_length (rsp_decoded_length)
   );

endmodule
